// ===== rtl/bsbb_pkg.sv =====
// ----------------------------------------------------------------------------
// bsbb_pkg: shared types and constants for the scaling blitter
// Transaction payloads, register indexes and fixed field widths.
// ----------------------------------------------------------------------------
package bsbb_pkg;

    // Fixed field widths
    localparam int SRC_DIM_W  = 7;
    localparam int DEST_POS_W = 12;
    localparam int DEST_DIM_W = 13;
    localparam int STEP_W     = 23;
    localparam int CFG_DATA_W = 13;

    // Parameter defaults
    localparam int SRC_MAX_WIDTH_DEF  = 64;
    localparam int SRC_MAX_HEIGHT_DEF = 64;
    localparam int FB_MAX_WIDTH_DEF   = 2048;
    localparam int FB_MAX_HEIGHT_DEF  = 2048;

    // Operation codes
    localparam logic OP_LOAD    = 1'b0;
    localparam logic OP_COMPOSE = 1'b1;

    // Step after reset: one source pixel over one destination pixel
    localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(1 << 16);

    typedef enum logic [2:0] {
        CFG_SRC_WIDTH   = 3'd0,
        CFG_SRC_HEIGHT  = 3'd1,
        CFG_DEST_X      = 3'd2,
        CFG_DEST_Y      = 3'd3,
        CFG_DEST_WIDTH  = 3'd4,
        CFG_DEST_HEIGHT = 3'd5,
        CFG_BLEND       = 3'd6,
        CFG_UNUSED      = 3'd7
    } cfg_index_t;

    typedef struct packed {
        logic        operation;
        logic [5:0]  load_col;
        logic [5:0]  load_row;
        logic [31:0] load_value;
        logic [10:0] fb_col;
        logic [10:0] fb_row;
        logic [31:0] fb_old;
    } item_t;

    typedef struct packed {
        logic [31:0] new_pixel;
        logic        write_enable;
    } result_t;

    // Step divider status
    typedef struct packed {
        logic              busy;
        logic              done;
        logic [STEP_W-1:0] quo;
    } div_status_t;

endpackage

// ===== rtl/bilinear_scale_blend_blit.sv =====
// ----------------------------------------------------------------------------
// bilinear_scale_blend_blit: bilinear scaler with premultiplied over-blend
// Loads a BGRA source image and composes scaled framebuffer pixels.
// ----------------------------------------------------------------------------
// Load transactions write the source image; compose transactions return one
// result each after stages A to G and a result register, at one transaction
// per clock while neither the dividers nor the result stall the pipeline.
// The image sits in four single-port banks split by row and column parity,
// so the four bilinear neighbours are fetched in the same cycle; loads and
// reads share the bank port at one pipeline stage, keeping program order.
// Each register write restarts the step dividers, which hold off input
// transactions while busy; a result not taken stalls the whole pipeline.
module bilinear_scale_blend_blit #(
    parameter int SRC_MAX_WIDTH  = bsbb_pkg::SRC_MAX_WIDTH_DEF,
    parameter int SRC_MAX_HEIGHT = bsbb_pkg::SRC_MAX_HEIGHT_DEF,
    parameter int FB_MAX_WIDTH   = bsbb_pkg::FB_MAX_WIDTH_DEF,
    parameter int FB_MAX_HEIGHT  = bsbb_pkg::FB_MAX_HEIGHT_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  bsbb_pkg::cfg_index_t                cfg_index,
    input  logic [bsbb_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                item_valid,
    output logic                                item_ready,
    input  bsbb_pkg::item_t                     item,
    output logic                                result_valid,
    input  logic                                result_ready,
    output bsbb_pkg::result_t                   result
);
    import bsbb_pkg::*;

    localparam int HALF_W  = (SRC_MAX_WIDTH + 1) / 2;
    localparam int HALF_H  = (SRC_MAX_HEIGHT + 1) / 2;
    localparam int BANK_D  = HALF_W * HALF_H;
    localparam int BANK_AW = (BANK_D > 1) ? $clog2(BANK_D) : 1;

    function automatic logic [BANK_AW-1:0] bank_addr(input logic [SRC_DIM_W-1:0] x,
                                                     input logic [SRC_DIM_W-1:0] y);
        int a;
        begin
            a = int'(y >> 1) * HALF_W + int'(x >> 1);
            return a[BANK_AW-1:0];
        end
    endfunction

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [SRC_DIM_W-1:0]         src_width_reg, src_height_reg;
    logic signed [DEST_POS_W-1:0] dest_x_reg, dest_y_reg;
    logic [DEST_DIM_W-1:0]        dest_width_reg, dest_height_reg;
    logic                         blend_reg;
    logic                         cfg_pend_reg;
    logic                         cfg_wr;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_width_reg   <= SRC_DIM_W'(1);
            src_height_reg  <= SRC_DIM_W'(1);
            dest_x_reg      <= '0;
            dest_y_reg      <= '0;
            dest_width_reg  <= DEST_DIM_W'(1);
            dest_height_reg <= DEST_DIM_W'(1);
            blend_reg       <= 1'b0;
            cfg_pend_reg    <= 1'b0;
        end
        else
        begin
            cfg_pend_reg <= cfg_wr;
            if (cfg_wr)
            begin
                unique case (cfg_index)
                    CFG_SRC_WIDTH:   src_width_reg   <= cfg_data[SRC_DIM_W-1:0];
                    CFG_SRC_HEIGHT:  src_height_reg  <= cfg_data[SRC_DIM_W-1:0];
                    CFG_DEST_X:      dest_x_reg      <= cfg_data[DEST_POS_W-1:0];
                    CFG_DEST_Y:      dest_y_reg      <= cfg_data[DEST_POS_W-1:0];
                    CFG_DEST_WIDTH:  dest_width_reg  <= cfg_data;
                    CFG_DEST_HEIGHT: dest_height_reg <= cfg_data;
                    CFG_BLEND:       blend_reg       <= cfg_data[0];
                    default:         ;
                endcase
            end
        end
    end

    // Effective source sizes, saturated at the image memory size
    logic [SRC_DIM_W-1:0] sw_eff, sh_eff;
    assign sw_eff = (int'(src_width_reg) > SRC_MAX_WIDTH)
                  ? SRC_DIM_W'(SRC_MAX_WIDTH) : src_width_reg;
    assign sh_eff = (int'(src_height_reg) > SRC_MAX_HEIGHT)
                  ? SRC_DIM_W'(SRC_MAX_HEIGHT) : src_height_reg;

    // ------------------------------------------------------------------
    // Step dividers
    // ------------------------------------------------------------------
    div_status_t       div_x, div_y;
    logic [STEP_W-1:0] step_x_reg, step_y_reg;
    logic              div_busy;

    bsbb_div u_div_x (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cfg_pend_reg),
        .num    ({sw_eff, 16'h0000}),
        .den    (dest_width_reg),
        .status (div_x)
    );

    bsbb_div u_div_y (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cfg_pend_reg),
        .num    ({sh_eff, 16'h0000}),
        .den    (dest_height_reg),
        .status (div_y)
    );

    assign div_busy = div_x.busy || div_y.busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_x_reg <= STEP_RESET;
            step_y_reg <= STEP_RESET;
        end
        else
        begin
            if (div_x.done)
            begin
                step_x_reg <= div_x.quo;
            end
            if (div_y.done)
            begin
                step_y_reg <= div_y.quo;
            end
        end
    end

    // ------------------------------------------------------------------
    // Pipeline control: all stages move together
    // ------------------------------------------------------------------
    logic adv;
    logic accept;
    logic result_valid_reg;
    result_t result_reg;

    assign adv        = !result_valid_reg || result_ready;
    assign item_ready = adv && !cfg_pend_reg && !div_busy;
    assign accept     = item_valid && item_ready;

    // Stage A: input register, rectangle test
    logic  a_valid_reg;
    item_t a_item_reg;
    logic signed [DEST_DIM_W:0] a_dx, a_dy;
    logic  a_inside;

    always_comb
    begin
        a_dx = $signed({3'b000, a_item_reg.fb_col})
             - $signed({{2{dest_x_reg[DEST_POS_W-1]}}, dest_x_reg});
        a_dy = $signed({3'b000, a_item_reg.fb_row})
             - $signed({{2{dest_y_reg[DEST_POS_W-1]}}, dest_y_reg});
        a_inside = (sw_eff != '0) && (sh_eff != '0)
                && (int'(a_item_reg.fb_col) < FB_MAX_WIDTH)
                && (int'(a_item_reg.fb_row) < FB_MAX_HEIGHT)
                && !a_dx[DEST_DIM_W] && (a_dx[DEST_DIM_W-1:0] < dest_width_reg)
                && !a_dy[DEST_DIM_W] && (a_dy[DEST_DIM_W-1:0] < dest_height_reg);
    end

    // Stage B: offset times step
    logic  b_valid_reg;
    item_t b_item_reg;
    logic  b_inside_reg;
    logic [DEST_POS_W-1:0] b_dx_reg, b_dy_reg;

    // Stage C: position, clamp, neighbours, bank access
    logic  c_valid_reg;
    item_t c_item_reg;
    logic  c_inside_reg;
    logic [DEST_POS_W+STEP_W-1:0] c_px_reg, c_py_reg;

    logic signed [DEST_POS_W+STEP_W+1:0] c_fx, c_fy;
    logic [STEP_W-1:0]    c_fxc, c_fyc, c_maxx, c_maxy;
    logic [SRC_DIM_W-1:0] c_sx0, c_sy0, c_sx1, c_sy1;
    logic [SRC_DIM_W:0]   c_sx0p1, c_sy0p1;
    logic                 c_xcl, c_ycl;

    always_comb
    begin
        c_maxx = {SRC_DIM_W'(sw_eff - 1'b1), 16'h0000};
        c_maxy = {SRC_DIM_W'(sh_eff - 1'b1), 16'h0000};
        c_fx = $signed({2'b00, c_px_reg}) + $signed({14'h0, step_x_reg >> 1})
             - $signed((DEST_POS_W+STEP_W+2)'(1 << 15));
        c_fy = $signed({2'b00, c_py_reg}) + $signed({14'h0, step_y_reg >> 1})
             - $signed((DEST_POS_W+STEP_W+2)'(1 << 15));
        if (c_fx < 0)
        begin
            c_fxc = '0;
        end
        else if (c_fx > $signed({14'h0, c_maxx}))
        begin
            c_fxc = c_maxx;
        end
        else
        begin
            c_fxc = c_fx[STEP_W-1:0];
        end
        if (c_fy < 0)
        begin
            c_fyc = '0;
        end
        else if (c_fy > $signed({14'h0, c_maxy}))
        begin
            c_fyc = c_maxy;
        end
        else
        begin
            c_fyc = c_fy[STEP_W-1:0];
        end
        c_sx0   = c_fxc[STEP_W-1:16];
        c_sy0   = c_fyc[STEP_W-1:16];
        c_sx0p1 = {1'b0, c_sx0} + 1'b1;
        c_sy0p1 = {1'b0, c_sy0} + 1'b1;
        c_xcl   = !(c_sx0p1 < {1'b0, sw_eff});
        c_ycl   = !(c_sy0p1 < {1'b0, sh_eff});
        c_sx1   = c_xcl ? c_sx0 : c_sx0p1[SRC_DIM_W-1:0];
        c_sy1   = c_ycl ? c_sy0 : c_sy0p1[SRC_DIM_W-1:0];
    end

    // Image banks, indexed [row parity][column parity]
    logic                c_load_ok;
    logic [BANK_AW-1:0]  c_waddr;
    logic [31:0]         bank_rdata [2][2];

    assign c_load_ok = (c_item_reg.operation == OP_LOAD)
                    && (int'(c_item_reg.load_col) < SRC_MAX_WIDTH)
                    && (int'(c_item_reg.load_row) < SRC_MAX_HEIGHT);
    assign c_waddr   = bank_addr(SRC_DIM_W'(c_item_reg.load_col),
                                 SRC_DIM_W'(c_item_reg.load_row));

    for (genvar by = 0; by < 2; by++)
    begin : g_bank_row
        for (genvar bx = 0; bx < 2; bx++)
        begin : g_bank_col
            logic [SRC_DIM_W-1:0] xs, ys;
            logic                 we;
            logic [BANK_AW-1:0]   addr;

            assign xs   = (c_sx0[0] == 1'(bx)) ? c_sx0 : c_sx1;
            assign ys   = (c_sy0[0] == 1'(by)) ? c_sy0 : c_sy1;
            assign we   = c_valid_reg && c_load_ok
                       && (c_item_reg.load_col[0] == 1'(bx))
                       && (c_item_reg.load_row[0] == 1'(by));
            assign addr = we ? c_waddr : bank_addr(xs, ys);

            bsbb_ram #(
                .WIDTH (32),
                .DEPTH (BANK_D)
            ) u_ram (
                .clk   (clk),
                .en    (adv && c_valid_reg),
                .we    (we),
                .addr  (addr),
                .wdata (c_item_reg.load_value),
                .rdata (bank_rdata[by][bx])
            );
        end
    end

    // Stage D: bank data present, neighbour selection and weights
    logic  d_valid_reg;
    item_t d_item_reg;
    logic  d_inside_reg;
    logic  d_x0p_reg, d_y0p_reg, d_xcl_reg, d_ycl_reg;
    logic [7:0] d_wx1_reg, d_wy1_reg;

    logic [31:0] d_p [4];
    logic [8:0]  d_wx0, d_wy0;
    logic [16:0] d_w [4];

    always_comb
    begin
        d_p[0] = bank_rdata[d_y0p_reg][d_x0p_reg];
        d_p[1] = d_xcl_reg ? d_p[0] : bank_rdata[d_y0p_reg][!d_x0p_reg];
        d_p[2] = d_ycl_reg ? d_p[0] : bank_rdata[!d_y0p_reg][d_x0p_reg];
        d_p[3] = d_ycl_reg ? d_p[1]
               : (d_xcl_reg ? d_p[2] : bank_rdata[!d_y0p_reg][!d_x0p_reg]);
        d_wx0  = 9'd256 - {1'b0, d_wx1_reg};
        d_wy0  = 9'd256 - {1'b0, d_wy1_reg};
        d_w[0] = 17'(d_wx0 * d_wy0);
        d_w[1] = 17'({1'b0, d_wx1_reg} * d_wy0);
        d_w[2] = 17'(d_wx0 * {1'b0, d_wy1_reg});
        d_w[3] = 17'({1'b0, d_wx1_reg} * {1'b0, d_wy1_reg});
    end

    // Stage E: weighted sum per channel, 24 bits hold 255 * 65536
    logic  e_valid_reg;
    item_t e_item_reg;
    logic  e_inside_reg;
    logic [31:0] e_p_reg [4];
    logic [16:0] e_w_reg [4];
    logic [7:0]  e_res [4];

    always_comb
    begin
        for (int c = 0; c < 4; c++)
        begin
            e_res[c] = 8'(({16'h0000, e_p_reg[0][c*8 +: 8]} * e_w_reg[0]
                        + {16'h0000, e_p_reg[1][c*8 +: 8]} * e_w_reg[1]
                        + {16'h0000, e_p_reg[2][c*8 +: 8]} * e_w_reg[2]
                        + {16'h0000, e_p_reg[3][c*8 +: 8]} * e_w_reg[3]) >> 16);
        end
    end

    // Stage F: coverage decision, old colour times inverse coverage
    logic  f_valid_reg;
    item_t f_item_reg;
    logic  f_inside_reg;
    logic [7:0] f_res_reg [4];
    logic [7:0] f_inv;
    logic       f_write, f_mix;

    assign f_inv   = 8'hFF - f_res_reg[3];
    assign f_write = f_inside_reg && !(blend_reg && (f_res_reg[3] == 8'h00));
    assign f_mix   = blend_reg && (f_res_reg[3] != 8'hFF);

    // Stage G: divide by 255, add, saturate
    logic  g_valid_reg;
    item_t g_item_reg;
    logic  g_write_reg, g_mix_reg;
    logic [7:0]  g_res_reg [3];
    logic [15:0] g_prod_reg [3];
    logic [7:0]  g_chan [3];
    logic [16:0] g_p1 [3];
    logic [24:0] g_t [3];
    logic [8:0]  g_sum [3];
    result_t     g_result;

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            // floor(p / 255) = ((p + 1) * 257) >> 16 for p below 65536
            g_p1[c]  = {1'b0, g_prod_reg[c]} + 1'b1;
            g_t[c]   = {g_p1[c], 8'h00} + {8'h00, g_p1[c]};
            g_sum[c] = {1'b0, g_res_reg[c]} + {1'b0, g_t[c][23:16]};
            if (!g_mix_reg)
            begin
                g_chan[c] = g_res_reg[c];
            end
            else if (g_sum[c][8])
            begin
                g_chan[c] = 8'hFF;
            end
            else
            begin
                g_chan[c] = g_sum[c][7:0];
            end
        end
        g_result.write_enable = g_write_reg;
        g_result.new_pixel    = g_write_reg ? {8'hFF, g_chan[2], g_chan[1], g_chan[0]}
                                            : g_item_reg.fb_old;
    end

    // Pipeline valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg      <= 1'b0;
            b_valid_reg      <= 1'b0;
            c_valid_reg      <= 1'b0;
            d_valid_reg      <= 1'b0;
            e_valid_reg      <= 1'b0;
            f_valid_reg      <= 1'b0;
            g_valid_reg      <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_valid_reg      <= accept;
            b_valid_reg      <= a_valid_reg;
            c_valid_reg      <= b_valid_reg;
            d_valid_reg      <= c_valid_reg;
            e_valid_reg      <= d_valid_reg;
            f_valid_reg      <= e_valid_reg;
            g_valid_reg      <= f_valid_reg;
            result_valid_reg <= g_valid_reg && (g_item_reg.operation == OP_COMPOSE);
        end
    end

    // Pipeline payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (accept)
            begin
                a_item_reg <= item;
            end
            b_item_reg   <= a_item_reg;
            b_inside_reg <= a_inside;
            b_dx_reg     <= a_dx[DEST_POS_W-1:0];
            b_dy_reg     <= a_dy[DEST_POS_W-1:0];

            c_item_reg   <= b_item_reg;
            c_inside_reg <= b_inside_reg;
            c_px_reg     <= b_dx_reg * step_x_reg;
            c_py_reg     <= b_dy_reg * step_y_reg;

            d_item_reg   <= c_item_reg;
            d_inside_reg <= c_inside_reg;
            d_x0p_reg    <= c_sx0[0];
            d_y0p_reg    <= c_sy0[0];
            d_xcl_reg    <= c_xcl;
            d_ycl_reg    <= c_ycl;
            d_wx1_reg    <= c_fxc[15:8];
            d_wy1_reg    <= c_fyc[15:8];

            e_item_reg   <= d_item_reg;
            e_inside_reg <= d_inside_reg;
            e_p_reg      <= d_p;
            e_w_reg      <= d_w;

            f_item_reg   <= e_item_reg;
            f_inside_reg <= e_inside_reg;
            f_res_reg    <= e_res;

            g_item_reg   <= f_item_reg;
            g_write_reg  <= f_write;
            g_mix_reg    <= f_mix;
            for (int c = 0; c < 3; c++)
            begin
                g_res_reg[c]  <= f_res_reg[c];
                g_prod_reg[c] <= f_item_reg.fb_old[c*8 +: 8] * f_inv;
            end

            result_reg   <= g_result;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_cfg_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_ready |=> !item_ready)
        else $error("input accepted while steps are recomputed");

    a_written_opaque: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.write_enable |-> result.new_pixel[31:24] == 8'hFF)
        else $error("written pixel without full alpha");

    a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        g_valid_reg && (g_item_reg.operation == OP_LOAD) && adv |=> !result_valid)
        else $error("load transaction produced a result");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> !item_ready || $stable(result))
        else $error("pipeline moved under a stalled result");

endmodule

// ===== rtl/bsbb_ram.sv =====
// ----------------------------------------------------------------------------
// bsbb_ram: generic single-port RAM
// One access per cycle, registered read data held while en is low.
// ----------------------------------------------------------------------------
module bsbb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             en,
    input  logic             we,
    input  logic [AW-1:0]    addr,
    input  logic [WIDTH-1:0] wdata,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            rdata <= mem[addr];
        end
    end

endmodule

// ===== rtl/bsbb_div.sv =====
// ----------------------------------------------------------------------------
// bsbb_div: step divider
// Restoring division of a 23-bit numerator by a 13-bit divisor, one
// quotient bit per cycle; a zero divisor gives zero.
// ----------------------------------------------------------------------------
module bsbb_div (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic [bsbb_pkg::STEP_W-1:0]         num,
    input  logic [bsbb_pkg::DEST_DIM_W-1:0]     den,
    output bsbb_pkg::div_status_t               status
);
    import bsbb_pkg::*;

    localparam int CNT_W = $clog2(STEP_W);

    logic                  busy_reg, busy_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [STEP_W-1:0]     num_reg, num_next;
    logic [STEP_W-1:0]     quo_reg, quo_next;
    logic [DEST_DIM_W-1:0] den_reg, den_next;
    logic [DEST_DIM_W-1:0] rem_reg, rem_next;
    logic [DEST_DIM_W:0]   rem_shift;
    logic                  done;

    // One restoring step per cycle
    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        rem_shift = {rem_reg, num_reg[STEP_W-1]};
        done      = 1'b0;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(STEP_W - 1);
            num_next  = num;
            den_next  = den;
            rem_next  = '0;
            quo_next  = '0;
        end
        else if (busy_reg)
        begin
            num_next = {num_reg[STEP_W-2:0], 1'b0};
            if (rem_shift >= {1'b0, den_reg})
            begin
                rem_next = DEST_DIM_W'(rem_shift - {1'b0, den_reg});
                quo_next = {quo_reg[STEP_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_shift[DEST_DIM_W-1:0];
                quo_next = {quo_reg[STEP_W-2:0], 1'b0};
            end
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done      = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
    end

    assign status.busy = busy_reg || start;
    assign status.done = done;
    assign status.quo  = (den_reg == '0) ? '0 : quo_next;

endmodule

// ===== dv/tb_bilinear_scale_blend_blit.sv =====
// ----------------------------------------------------------------------------
// tb_bilinear_scale_blend_blit: self-checking testbench for the scaling blitter
// Runs a directed table after reset, then a series of register settings, each
// loading the source area it reads, then random loads and composes. Results
// are checked in order against table values or a bilinear/over-blend predictor.
// ----------------------------------------------------------------------------
module tb_bilinear_scale_blend_blit;
    timeunit 1ns;
    timeprecision 1ps;

    import bsbb_pkg::*;

    localparam int SRC_W_MAX    = 64;
    localparam int SRC_H_MAX    = 64;
    localparam int FB_W_MAX     = 2048;
    localparam int FB_H_MAX     = 2048;
    localparam int DRAIN_CYCLES = 12;
    localparam int STALL_LIMIT  = 3000;
    localparam int PRESSURE_LEN = 400;
    localparam int PHASE_ITEMS  = 50;

    logic           clk;
    logic           rst_n;
    logic           cfg_valid;
    logic           cfg_ready;
    cfg_index_t     cfg_index;
    logic [12:0]    cfg_data;
    logic           item_valid;
    logic           item_ready;
    item_t          item;
    logic           result_valid;
    logic           result_ready;
    result_t        result;

    bilinear_scale_blend_blit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    // Clock, 12 ns period
    initial clk = 1'b0;
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Predictor state
    logic [31:0] src_img [SRC_W_MAX*SRC_H_MAX];
    bit          loaded  [SRC_W_MAX*SRC_H_MAX];
    int          reg_sw, reg_sh, reg_dw, reg_dh, reg_dx, reg_dy;
    bit          reg_blend;
    int          step_x, step_y;

    result_t     pixel_q [$];
    int          err_count;
    int          results_seen;
    bit          gappy_send, gappy_recv;
    bit          pressure_done;
    int          stall_left;
    int          idle_cycles;

    function automatic int clamp_size(int v, int maxv);
        return (v > maxv) ? maxv : v;
    endfunction

    function automatic int scale_step(int src, int dst);
        if (dst == 0)
            return 0;
        return ((src << 16) / dst) & 'h7FFFFF;
    endfunction

    function automatic void refresh_steps();
        step_x = scale_step(clamp_size(reg_sw, SRC_W_MAX), reg_dw);
        step_y = scale_step(clamp_size(reg_sh, SRC_H_MAX), reg_dh);
    endfunction

    function automatic void apply_reg(cfg_index_t idx, logic [12:0] d);
        case (idx)
            CFG_SRC_WIDTH:   reg_sw = int'(d[6:0]);
            CFG_SRC_HEIGHT:  reg_sh = int'(d[6:0]);
            CFG_DEST_X:      reg_dx = int'($signed(d[11:0]));
            CFG_DEST_Y:      reg_dy = int'($signed(d[11:0]));
            CFG_DEST_WIDTH:  reg_dw = int'(d);
            CFG_DEST_HEIGHT: reg_dh = int'(d);
            CFG_BLEND:       reg_blend = d[0];
            default:         return;
        endcase
        refresh_steps();
    endfunction

    // Clamped 16.16 source position
    function automatic longint src_position(longint d, int stp, int src);
        longint f;
        longint fmax;
        f = d * longint'(stp) + longint'(stp >> 1) - longint'(1 << 15);
        fmax = longint'(src - 1) * 65536;
        if (f > fmax) f = fmax;
        if (f < 0) f = 0;
        return f;
    endfunction

    // Bilinear sample plus optional premultiplied over-blend
    function automatic result_t blit_pixel(item_t it);
        result_t r;
        int      sw, sh, sx0, sx1, sy0, sy1, wx1, wy1, inv, acc, v;
        int      wt [4];
        int      chn [4];
        longint  col, row, fx, fy;
        logic [31:0] nb [4];
        r.new_pixel    = it.fb_old;
        r.write_enable = 1'b0;
        sw  = clamp_size(reg_sw, SRC_W_MAX);
        sh  = clamp_size(reg_sh, SRC_H_MAX);
        col = longint'(it.fb_col);
        row = longint'(it.fb_row);
        if (sw == 0 || sh == 0 || reg_dw == 0 || reg_dh == 0)
            return r;
        if (col >= FB_W_MAX || row >= FB_H_MAX)
            return r;
        if (col < reg_dx || col >= longint'(reg_dx) + reg_dw)
            return r;
        if (row < reg_dy || row >= longint'(reg_dy) + reg_dh)
            return r;
        fx  = src_position(col - reg_dx, step_x, sw);
        fy  = src_position(row - reg_dy, step_y, sh);
        sx0 = int'(fx >> 16);
        sy0 = int'(fy >> 16);
        sx1 = (sx0 + 1 < sw) ? sx0 + 1 : sw - 1;
        sy1 = (sy0 + 1 < sh) ? sy0 + 1 : sh - 1;
        wx1 = int'((fx >> 8) & 'hFF);
        wy1 = int'((fy >> 8) & 'hFF);
        wt[0] = (256 - wx1) * (256 - wy1);
        wt[1] = wx1 * (256 - wy1);
        wt[2] = (256 - wx1) * wy1;
        wt[3] = wx1 * wy1;
        nb[0] = src_img[sy0*SRC_W_MAX + sx0];
        nb[1] = src_img[sy0*SRC_W_MAX + sx1];
        nb[2] = src_img[sy1*SRC_W_MAX + sx0];
        nb[3] = src_img[sy1*SRC_W_MAX + sx1];
        for (int c = 0; c < 4; c++)
        begin
            acc = 0;
            for (int k = 0; k < 4; k++)
                acc += int'((nb[k] >> (8*c)) & 'hFF) * wt[k];
            chn[c] = acc >> 16;
        end
        if (reg_blend && chn[3] == 0)
            return r;
        if (reg_blend && chn[3] < 255)
        begin
            inv = 255 - chn[3];
            for (int c = 0; c < 3; c++)
            begin
                v = chn[c] + (int'((it.fb_old >> (8*c)) & 'hFF) * inv) / 255;
                chn[c] = (v > 255) ? 255 : v;
            end
        end
        r.new_pixel    = {8'hFF, chn[2][7:0], chn[1][7:0], chn[0][7:0]};
        r.write_enable = 1'b1;
        return r;
    endfunction

    function automatic int gap_len(bit gappy);
        int r;
        if (!gappy)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Source pixel with a spread of coverage values
    function automatic logic [31:0] rand_pixel();
        case ($urandom_range(0, 3))
            0:       return {8'h00, 24'($urandom)};
            1:       return {8'hFF, 24'($urandom)};
            default: return $urandom;
        endcase
    endfunction

    // Transaction send; the model is updated on acceptance
    task automatic send_item(item_t it, bit typed, result_t typed_res);
        int g;
        @(negedge clk);
        item_valid <= 1'b1;
        item       <= it;
        do @(posedge clk); while (!item_ready);
        if (it.operation == OP_LOAD)
        begin
            src_img[it.load_row*SRC_W_MAX + it.load_col] = it.load_value;
            loaded[it.load_row*SRC_W_MAX + it.load_col]  = 1'b1;
        end
        else
            pixel_q.push_back(typed ? typed_res : blit_pixel(it));
        g = gap_len(gappy_send);
        if (g > 0)
        begin
            @(negedge clk);
            item_valid <= 1'b0;
            repeat (g - 1) @(negedge clk);
        end
    endtask

    task automatic drain();
        @(negedge clk);
        item_valid <= 1'b0;
        while (pixel_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(cfg_index_t idx, logic [12:0] d);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        do @(posedge clk); while (!cfg_ready);
        apply_reg(idx, d);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [10:0] pick_coord(int base, int len);
        int v;
        if (len > 0 && $urandom_range(0, 3) != 0)
        begin
            if ($urandom_range(0, 7) == 0)
                v = $urandom_range(0, 1) ? base : base + len - 1;
            else
                v = base + $urandom_range(0, clamp_size(len, 4096) - 1);
            if (v >= 0 && v < FB_W_MAX)
                return 11'(v);
        end
        return 11'($urandom);
    endfunction

    // One register setting: program, load the area it reads, then random traffic
    task automatic run_phase(int sw, int sh, int dx, int dy, int dw, int dh, int bl,
                             int n);
        item_t   it;
        result_t none;
        int      esw, esh;
        none = '0;
        drain();
        write_reg(CFG_SRC_WIDTH,   13'(sw));
        write_reg(CFG_SRC_HEIGHT,  13'(sh));
        write_reg(CFG_DEST_X,      13'(dx));
        write_reg(CFG_DEST_Y,      13'(dy));
        write_reg(CFG_DEST_WIDTH,  13'(dw));
        write_reg(CFG_DEST_HEIGHT, 13'(dh));
        write_reg(CFG_BLEND,       13'(bl));
        gappy_send = $urandom_range(0, 3) != 0;
        gappy_recv = $urandom_range(0, 3) != 0;
        esw = clamp_size(reg_sw, SRC_W_MAX);
        esh = clamp_size(reg_sh, SRC_H_MAX);
        for (int y = 0; y < esh; y++)
            for (int x = 0; x < esw; x++)
                if (!loaded[y*SRC_W_MAX + x])
                begin
                    it = item_t'({$urandom, $urandom, $urandom});
                    it.operation  = OP_LOAD;
                    it.load_col   = 6'(x);
                    it.load_row   = 6'(y);
                    it.load_value = rand_pixel();
                    send_item(it, 1'b0, none);
                end
        for (int i = 0; i < n; i++)
        begin
            it = item_t'({$urandom, $urandom, $urandom});
            if ($urandom_range(0, 6) == 0)
            begin
                it.operation  = OP_LOAD;
                it.load_value = rand_pixel();
                if (esw > 0 && esh > 0 && $urandom_range(0, 1))
                begin
                    it.load_col = 6'($urandom_range(0, esw - 1));
                    it.load_row = 6'($urandom_range(0, esh - 1));
                end
            end
            else
            begin
                it.operation = OP_COMPOSE;
                it.fb_col    = pick_coord(reg_dx, reg_dw);
                it.fb_row    = pick_coord(reg_dy, reg_dh);
            end
            send_item(it, 1'b0, none);
        end
    endtask

    // Directed table, run on the reset register values (1x1 source, replace)
    typedef struct packed {
        logic        op;
        logic [5:0]  lcol;
        logic [5:0]  lrow;
        logic [31:0] lval;
        logic [10:0] col;
        logic [10:0] row;
        logic [31:0] old;
        logic        typed;
        logic [31:0] px;
        logic        we;
    } dir_row_t;

    localparam int DIR_ROWS = 12;
    dir_row_t dir_tab [DIR_ROWS] = '{
        '{OP_LOAD,    6'd0,  6'd0,  32'h8011_2233, 11'd0,    11'd0,    32'h0, 1'b0, 32'h0, 1'b0},
        '{OP_COMPOSE, 6'd0,  6'd0,  32'h0, 11'd0,    11'd0,    32'hDEAD_BEEF,
          1'b1, 32'hFF11_2233, 1'b1},
        '{OP_COMPOSE, 6'd0,  6'd0,  32'h0, 11'd1,    11'd0,    32'h1234_5678,
          1'b1, 32'h1234_5678, 1'b0},
        '{OP_COMPOSE, 6'd0,  6'd0,  32'h0, 11'd0,    11'd1,    32'h0,
          1'b1, 32'h0, 1'b0},
        '{OP_COMPOSE, 6'd0,  6'd0,  32'h0, 11'd2047, 11'd2047, 32'hFFFF_FFFF,
          1'b1, 32'hFFFF_FFFF, 1'b0},
        '{OP_LOAD,    6'd63, 6'd63, 32'hFFFF_FFFF, 11'd0, 11'd0, 32'h0, 1'b0, 32'h0, 1'b0},
        '{OP_LOAD,    6'd0,  6'd0,  32'h0, 11'd0,    11'd0,    32'h0, 1'b0, 32'h0, 1'b0},
        '{OP_COMPOSE, 6'd0,  6'd0,  32'h0, 11'd0,    11'd0,    32'hFFFF_FFFF,
          1'b1, 32'hFF00_0000, 1'b1},
        '{OP_LOAD,    6'd0,  6'd0,  32'hFFFF_FFFF, 11'd0, 11'd0, 32'h0, 1'b0, 32'h0, 1'b0},
        '{OP_COMPOSE, 6'd0,  6'd0,  32'h0, 11'd0,    11'd0,    32'h0,
          1'b1, 32'hFFFF_FFFF, 1'b1},
        '{OP_LOAD,    6'd32, 6'd17, 32'h5A5A_5A5A, 11'd0, 11'd0, 32'h0, 1'b0, 32'h0, 1'b0},
        '{OP_COMPOSE, 6'd0,  6'd0,  32'h0, 11'd0,    11'd0,    32'h1357_2468,
          1'b0, 32'h0, 1'b0}
    };

    // Stimulus
    initial
    begin
        item_t   it;
        result_t tr;
        cfg_valid    = 1'b0;
        cfg_index    = CFG_SRC_WIDTH;
        cfg_data     = '0;
        item_valid   = 1'b0;
        item         = '0;
        err_count    = 0;
        gappy_send   = 1'b0;
        gappy_recv   = 1'b0;
        reg_sw = 1; reg_sh = 1; reg_dw = 1; reg_dh = 1;
        reg_dx = 0; reg_dy = 0; reg_blend = 1'b0;
        refresh_steps();
        for (int i = 0; i < SRC_W_MAX*SRC_H_MAX; i++)
        begin
            src_img[i] = '0;
            loaded[i]  = 1'b0;
        end
        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (dir_tab[i])
        begin
            it = '0;
            it.operation  = dir_tab[i].op;
            it.load_col   = dir_tab[i].lcol;
            it.load_row   = dir_tab[i].lrow;
            it.load_value = dir_tab[i].lval;
            it.fb_col     = dir_tab[i].col;
            it.fb_row     = dir_tab[i].row;
            it.fb_old     = dir_tab[i].old;
            tr.new_pixel    = dir_tab[i].px;
            tr.write_enable = dir_tab[i].we;
            send_item(it, dir_tab[i].typed, tr);
        end

        // Settings: up- and down-scaling, extremes of the width, position and blend registers
        run_phase(8,   6,     100,   50,   40,   30,   0, PHASE_ITEMS);
        run_phase(8,   6,     -5,    -3,   20,   12,   1, PHASE_ITEMS);
        run_phase(64,  2,     0,     0,    4096, 4096, 1, PHASE_ITEMS);
        run_phase(2,   64,    -2048, -2048, 4096, 4096, 0, PHASE_ITEMS);
        run_phase(1,   1,     2047,  2047, 1,    1,    1, PHASE_ITEMS);
        run_phase(127, 3,     10,    10,   7,    5,    1, PHASE_ITEMS);
        run_phase(0,   5,     0,     0,    9,    9,    0, PHASE_ITEMS / 3);
        run_phase(5,   5,     0,     0,    0,    3,    1, PHASE_ITEMS / 3);
        run_phase(3,   64,    0,     -1,   8191, 2,    1, PHASE_ITEMS);
        for (int p = 0; p < 5; p++)
            run_phase($urandom_range(1, 16), $urandom_range(1, 16),
                      $urandom_range(0, 40) - 20, $urandom_range(0, 40) - 20,
                      $urandom_range(1, 100), $urandom_range(1, 100),
                      $urandom_range(0, 1), PHASE_ITEMS);

        drain();
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Result side: random back-pressure and one long hold-off
    initial
    begin
        int r;
        result_ready  = 1'b0;
        stall_left    = 0;
        pressure_done = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!pressure_done && results_seen >= 250)
            begin
                pressure_done = 1'b1;
                stall_left    = PRESSURE_LEN;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                result_ready <= 1'b0;
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (gappy_recv && r < 3)
                    stall_left = $urandom_range(10, 40);
                else if (gappy_recv && r < 30)
                    stall_left = $urandom_range(0, 2);
                result_ready <= !(gappy_recv && r < 30);
            end
        end
    end

    // Result check against the oldest expected pixel
    initial results_seen = 0;
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && result_valid && result_ready)
        begin
            results_seen++;
            if (pixel_q.size() == 0)
            begin
                $error("unexpected result transaction: new_pixel %h write_enable %b",
                       result.new_pixel, result.write_enable);
                err_count++;
            end
            else
            begin
                want = pixel_q.pop_front();
                if (result.new_pixel !== want.new_pixel)
                begin
                    $error("new_pixel: expected %h, actual %h",
                           want.new_pixel, result.new_pixel);
                    err_count++;
                end
                if (result.write_enable !== want.write_enable)
                begin
                    $error("write_enable: expected %b, actual %b",
                           want.write_enable, result.write_enable);
                    err_count++;
                end
            end
        end
    end

    // Watchdog on cycles with no transaction on any channel
    initial idle_cycles = 0;
    always @(posedge clk)
    begin
        if ((item_valid && item_ready) || (cfg_valid && cfg_ready) ||
            (result_valid && result_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

endmodule

// ===== filelist.f =====
rtl/bsbb_pkg.sv
rtl/bsbb_ram.sv
rtl/bsbb_div.sv
rtl/bilinear_scale_blend_blit.sv
dv/tb_bilinear_scale_blend_blit.sv
